// ----- rtl/assert_macros.svh -----
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define MMP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked on every clock edge, reset included
`define MMP_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/mmp_pkg.sv -----
// types, constants, message rom and morse table of the message player
package mmp_pkg;

  localparam int SLOT_COUNT    = 5;
  localparam int MAX_MSG_CHARS = 16;
  localparam int MAX_ELEMENTS  = 7;

  localparam int SLOT_W  = 3;
  localparam int CHAR_W  = 8;
  localparam int CIDX_W  = $clog2(MAX_MSG_CHARS + 1);
  localparam int ELEM_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int DIT_W   = 11;
  localparam int MULT_W  = 4;
  localparam int PROD_W  = DIT_W + MULT_W;
  localparam int TIME_W  = 16;
  localparam int REQ_W   = 2;
  localparam int CFGI_W  = 2;
  localparam int MSG_BITS = MAX_MSG_CHARS * CHAR_W;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // request codes on the input side
  localparam logic [REQ_W-1:0] REQ_TICK = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PLAY = 2'd1;
  localparam logic [REQ_W-1:0] REQ_STOP = 2'd2;

  // configuration register indexes
  localparam logic [CFGI_W-1:0] CFG_DIT_LENGTH = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_CHAR_GAP   = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_WORD_GAP   = 2'd2;

  localparam logic [DIT_W-1:0]  DIT_RESET      = 11'd60;
  localparam logic [MULT_W-1:0] CHAR_GAP_RESET = 4'd3;
  localparam logic [MULT_W-1:0] WORD_GAP_RESET = 4'd7;

  localparam logic [CHAR_W-1:0] CH_SPACE = " ";
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

  // message text, first character in the top byte
  localparam logic [MSG_BITS-1:0] MSG0 = {"CQ CQ CQ", {(MAX_MSG_CHARS - 8){8'h00}}};
  localparam logic [MSG_BITS-1:0] MSG1 = {"599 599", {(MAX_MSG_CHARS - 7){8'h00}}};
  localparam logic [MSG_BITS-1:0] MSG2 = {"TU TU", {(MAX_MSG_CHARS - 5){8'h00}}};
  localparam logic [MSG_BITS-1:0] MSG3 = {"QRZ?", {(MAX_MSG_CHARS - 4){8'h00}}};
  localparam logic [MSG_BITS-1:0] MSG4 = {"AR AR", {(MAX_MSG_CHARS - 5){8'h00}}};

  localparam logic [SLOT_COUNT-1:0][MSG_BITS-1:0] MSG_ROM = {MSG4, MSG3, MSG2, MSG1, MSG0};

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_PLAY,
    CMD_STOP,
    CMD_REFUSE,
    CMD_NOP
  } cmd_kind_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TONE,
    PH_GAP
  } phase_e;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_EXEC,
    SEQ_LOAD,
    SEQ_START,
    SEQ_EMIT
  } seq_state_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [SLOT_W-1:0] slot;
    logic              grant;
  } cmd_t;

  typedef struct packed {
    logic              tone_on;
    logic              playing;
    logic [SLOT_W-1:0] slot;
    logic              accepted;
  } res_t;

  typedef struct packed {
    logic                    ok;
    logic [ELEM_W-1:0]       len;
    logic [MAX_ELEMENTS-1:0] bits;
  } pat_t;

  function automatic logic [CHAR_W-1:0] rom_char(input logic [SLOT_W-1:0] slot,
                                                  input logic [CIDX_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    c = CH_NUL;
    if ((int'(slot) < SLOT_COUNT) && (int'(idx) < MAX_MSG_CHARS)) begin
      c = MSG_ROM[slot][(MAX_MSG_CHARS - 1 - int'(idx)) * CHAR_W +: CHAR_W];
    end
    return c;
  endfunction

  // bit i set means element i is a dah
  function automatic pat_t lookup_char(input logic [CHAR_W-1:0] c_in);
    logic [CHAR_W-1:0] c;
    logic [3:0]        len;
    logic [7:0]        bits;
    pat_t              r;
    c    = c_in;
    len  = 4'd0;
    bits = 8'h00;
    if (c inside {["a":"z"]}) begin
      c = c - 8'd32;
    end
    case (c)
      "A": begin len = 4'd2; bits = 8'h02; end
      "B": begin len = 4'd4; bits = 8'h01; end
      "C": begin len = 4'd4; bits = 8'h05; end
      "D": begin len = 4'd3; bits = 8'h01; end
      "E": begin len = 4'd1; bits = 8'h00; end
      "F": begin len = 4'd4; bits = 8'h04; end
      "G": begin len = 4'd3; bits = 8'h03; end
      "H": begin len = 4'd4; bits = 8'h00; end
      "I": begin len = 4'd2; bits = 8'h00; end
      "J": begin len = 4'd4; bits = 8'h0E; end
      "K": begin len = 4'd3; bits = 8'h05; end
      "L": begin len = 4'd4; bits = 8'h02; end
      "M": begin len = 4'd2; bits = 8'h03; end
      "N": begin len = 4'd2; bits = 8'h01; end
      "O": begin len = 4'd3; bits = 8'h07; end
      "P": begin len = 4'd4; bits = 8'h06; end
      "Q": begin len = 4'd4; bits = 8'h0B; end
      "R": begin len = 4'd3; bits = 8'h02; end
      "S": begin len = 4'd3; bits = 8'h00; end
      "T": begin len = 4'd1; bits = 8'h01; end
      "U": begin len = 4'd3; bits = 8'h04; end
      "V": begin len = 4'd4; bits = 8'h08; end
      "W": begin len = 4'd3; bits = 8'h06; end
      "X": begin len = 4'd4; bits = 8'h09; end
      "Y": begin len = 4'd4; bits = 8'h0D; end
      "Z": begin len = 4'd4; bits = 8'h03; end
      "0": begin len = 4'd5; bits = 8'h1F; end
      "1": begin len = 4'd5; bits = 8'h1E; end
      "2": begin len = 4'd5; bits = 8'h1C; end
      "3": begin len = 4'd5; bits = 8'h18; end
      "4": begin len = 4'd5; bits = 8'h10; end
      "5": begin len = 4'd5; bits = 8'h00; end
      "6": begin len = 4'd5; bits = 8'h01; end
      "7": begin len = 4'd5; bits = 8'h03; end
      "8": begin len = 4'd5; bits = 8'h07; end
      "9": begin len = 4'd5; bits = 8'h0F; end
      "?": begin len = 4'd6; bits = 8'h0C; end
      default: begin len = 4'd0; bits = 8'h00; end
    endcase
    r.ok   = (len != 4'd0) && (int'(len) <= MAX_ELEMENTS);
    r.len  = len[ELEM_W-1:0];
    r.bits = bits[MAX_ELEMENTS-1:0];
    return r;
  endfunction

endpackage

// ----- rtl/mmp_front.sv -----
// request decode and two-entry command queue
module mmp_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [mmp_pkg::REQ_W-1:0] req_type_i,
  input  logic [mmp_pkg::SLOT_W-1:0] slot_i,
  input  logic                      tx_active_i,
  input  logic                      tone_grant_i,
  output logic                      cmd_valid_o,
  output mmp_pkg::cmd_t             cmd_o,
  input  logic                      cmd_pop_i
);

  mmp_pkg::cmd_t cmd_in;
  mmp_pkg::cmd_t mem_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;
  logic          wr_en, rd_en;

  // refusals are settled here so the back end only replays current state
  always_comb begin
    cmd_in.slot  = slot_i;
    cmd_in.grant = tone_grant_i;
    case (req_type_i)
      mmp_pkg::REQ_TICK: cmd_in.kind = mmp_pkg::CMD_TICK;
      mmp_pkg::REQ_PLAY: begin
        if ((int'(slot_i) >= mmp_pkg::SLOT_COUNT) || tx_active_i) begin
          cmd_in.kind = mmp_pkg::CMD_REFUSE;
        end else begin
          cmd_in.kind = mmp_pkg::CMD_PLAY;
        end
      end
      mmp_pkg::REQ_STOP: cmd_in.kind = mmp_pkg::CMD_STOP;
      default:           cmd_in.kind = mmp_pkg::CMD_NOP;
    endcase
  end

  assign full        = (count_q == 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = mem_q[rd_ptr_q];
  assign wr_en       = push && !full;
  assign rd_en       = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ wr_en;
    rd_ptr_d = rd_ptr_q ^ rd_en;
    count_d  = count_q + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ----- rtl/mmp_back.sv -----
// playback sequencer, configuration registers and result queue
module mmp_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [mmp_pkg::CFGI_W-1:0] cfg_index_i,
  input  logic [mmp_pkg::DIT_W-1:0]  cfg_data_i,
  input  logic                       cmd_valid_i,
  input  mmp_pkg::cmd_t              cmd_i,
  output logic                       cmd_pop_o,
  output logic                       res_empty_o,
  input  logic                       res_pop_i,
  output mmp_pkg::res_t              res_o
);

  localparam int MW = mmp_pkg::MAX_ELEMENTS;

  mmp_pkg::seq_state_e state_q, state_d;
  mmp_pkg::cmd_t       cmd_q, cmd_d;
  mmp_pkg::phase_e     phase_q, phase_d;

  logic                          active_q, active_d;
  logic [mmp_pkg::SLOT_W-1:0]    slot_q, slot_d;
  logic [mmp_pkg::CIDX_W-1:0]    char_idx_q, char_idx_d;
  logic [MW-1:0]                 pat_bits_q, pat_bits_d;
  logic [mmp_pkg::ELEM_W-1:0]    pat_len_q, pat_len_d;
  logic [mmp_pkg::ELEM_W-1:0]    elem_idx_q, elem_idx_d;
  logic [mmp_pkg::TIME_W-1:0]    elapsed_q, elapsed_d;
  logic [mmp_pkg::TIME_W-1:0]    duration_q, duration_d;

  logic [mmp_pkg::DIT_W-1:0]     dit_q;
  logic [mmp_pkg::MULT_W-1:0]    char_gap_q, word_gap_q;

  mmp_pkg::res_t res_mem_q [2];
  logic          res_wr_q, res_rd_q;
  logic [1:0]    res_cnt_q;
  logic          res_full, res_push, res_pop;
  mmp_pkg::res_t res_new;

  // shared decode of the current step
  logic [mmp_pkg::TIME_W-1:0]  elapsed_inc;
  logic                        phase_running;
  logic [mmp_pkg::ELEM_W-1:0]  elem_next;
  logic [mmp_pkg::CHAR_W-1:0]  next_char;
  logic [mmp_pkg::MULT_W-1:0]  gap_mult;
  logic [mmp_pkg::PROD_W-1:0]  gap_prod;
  logic [mmp_pkg::CHAR_W-1:0]  load_char;
  mmp_pkg::pat_t               load_pat;
  logic [mmp_pkg::DIT_W+1:0]   dah_len;
  logic                        elem_is_dah;

  always_comb begin
    elapsed_inc   = (elapsed_q == mmp_pkg::TIME_MAX) ? elapsed_q : elapsed_q + 1'b1;
    phase_running = (elapsed_inc < duration_q);
    elem_next     = elem_idx_q + 1'b1;
    next_char     = mmp_pkg::rom_char(slot_q, char_idx_q);
    gap_mult      = ((next_char == mmp_pkg::CH_SPACE) || (next_char == mmp_pkg::CH_NUL)) ?
                    word_gap_q : char_gap_q;
    gap_prod      = mmp_pkg::PROD_W'(dit_q) * mmp_pkg::PROD_W'(gap_mult);
    load_char     = next_char;
    load_pat      = mmp_pkg::lookup_char(load_char);
    dah_len       = {1'b0, dit_q, 1'b0} + {2'b00, dit_q};
    elem_is_dah   = (int'(elem_idx_q) < MW) ? pat_bits_q[elem_idx_q[$clog2(MW)-1:0]] : 1'b0;
  end

  assign res_full = (res_cnt_q == 2'd2);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mmp_pkg::SEQ_IDLE: begin
        if (cmd_valid_i && !res_full) begin
          state_d = mmp_pkg::SEQ_EXEC;
        end
      end
      mmp_pkg::SEQ_EXEC: begin
        state_d = mmp_pkg::SEQ_EMIT;
        case (cmd_q.kind)
          mmp_pkg::CMD_PLAY: state_d = mmp_pkg::SEQ_LOAD;
          mmp_pkg::CMD_TICK: begin
            if (active_q && !phase_running && (phase_q != mmp_pkg::PH_TONE)) begin
              state_d = (elem_idx_q < pat_len_q) ? mmp_pkg::SEQ_START : mmp_pkg::SEQ_LOAD;
            end
          end
          default: state_d = mmp_pkg::SEQ_EMIT;
        endcase
      end
      mmp_pkg::SEQ_LOAD: begin
        if (load_char == mmp_pkg::CH_NUL) begin
          state_d = mmp_pkg::SEQ_EMIT;
        end else if ((load_char != mmp_pkg::CH_SPACE) && load_pat.ok) begin
          state_d = mmp_pkg::SEQ_START;
        end
      end
      mmp_pkg::SEQ_START: state_d = mmp_pkg::SEQ_EMIT;
      mmp_pkg::SEQ_EMIT:  state_d = mmp_pkg::SEQ_IDLE;
      default:            state_d = mmp_pkg::SEQ_IDLE;
    endcase
  end

  // datapath and strobes
  always_comb begin
    cmd_d      = cmd_q;
    active_d   = active_q;
    phase_d    = phase_q;
    slot_d     = slot_q;
    char_idx_d = char_idx_q;
    pat_bits_d = pat_bits_q;
    pat_len_d  = pat_len_q;
    elem_idx_d = elem_idx_q;
    elapsed_d  = elapsed_q;
    duration_d = duration_q;
    cmd_pop_o  = 1'b0;
    res_push   = 1'b0;

    res_new.tone_on  = active_q && (phase_q == mmp_pkg::PH_TONE);
    res_new.playing  = active_q;
    res_new.slot     = slot_q;
    res_new.accepted = (cmd_q.kind == mmp_pkg::CMD_PLAY) && active_q;

    case (state_q)
      mmp_pkg::SEQ_IDLE: begin
        if (cmd_valid_i && !res_full) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
        end
      end
      mmp_pkg::SEQ_EXEC: begin
        case (cmd_q.kind)
          mmp_pkg::CMD_STOP: begin
            active_d = 1'b0;
            phase_d  = mmp_pkg::PH_IDLE;
          end
          mmp_pkg::CMD_PLAY: begin
            active_d   = 1'b1;
            phase_d    = mmp_pkg::PH_IDLE;
            slot_d     = cmd_q.slot;
            char_idx_d = '0;
          end
          mmp_pkg::CMD_TICK: begin
            if (active_q) begin
              elapsed_d = elapsed_inc;
              if (!phase_running && (phase_q == mmp_pkg::PH_TONE)) begin
                // element over: short gap inside a character, else char or word gap
                elem_idx_d = elem_next;
                phase_d    = mmp_pkg::PH_GAP;
                elapsed_d  = '0;
                if (elem_next < pat_len_q) begin
                  duration_d = mmp_pkg::TIME_W'(dit_q);
                end else begin
                  duration_d = mmp_pkg::TIME_W'(gap_prod);
                end
              end
            end
          end
          default: ;
        endcase
      end
      mmp_pkg::SEQ_LOAD: begin
        if (load_char == mmp_pkg::CH_NUL) begin
          active_d = 1'b0;
          phase_d  = mmp_pkg::PH_IDLE;
        end else begin
          char_idx_d = char_idx_q + 1'b1;
          if ((load_char != mmp_pkg::CH_SPACE) && load_pat.ok) begin
            pat_bits_d = load_pat.bits;
            pat_len_d  = load_pat.len;
            elem_idx_d = '0;
          end
        end
      end
      mmp_pkg::SEQ_START: begin
        if (!cmd_q.grant) begin
          active_d = 1'b0;
          phase_d  = mmp_pkg::PH_IDLE;
        end else begin
          phase_d    = mmp_pkg::PH_TONE;
          elapsed_d  = '0;
          duration_d = elem_is_dah ? mmp_pkg::TIME_W'(dah_len) : mmp_pkg::TIME_W'(dit_q);
        end
      end
      mmp_pkg::SEQ_EMIT: res_push = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mmp_pkg::SEQ_IDLE;
      active_q   <= 1'b0;
      phase_q    <= mmp_pkg::PH_IDLE;
      slot_q     <= '0;
      char_idx_q <= '0;
      pat_bits_q <= '0;
      pat_len_q  <= '0;
      elem_idx_q <= '0;
      elapsed_q  <= '0;
      duration_q <= '0;
    end else begin
      state_q    <= state_d;
      active_q   <= active_d;
      phase_q    <= phase_d;
      slot_q     <= slot_d;
      char_idx_q <= char_idx_d;
      pat_bits_q <= pat_bits_d;
      pat_len_q  <= pat_len_d;
      elem_idx_q <= elem_idx_d;
      elapsed_q  <= elapsed_d;
      duration_q <= duration_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  // configuration registers, to be written only while the sequencer is quiet; the block does not enforce this
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dit_q      <= mmp_pkg::DIT_RESET;
      char_gap_q <= mmp_pkg::CHAR_GAP_RESET;
      word_gap_q <= mmp_pkg::WORD_GAP_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mmp_pkg::CFG_DIT_LENGTH: dit_q      <= cfg_data_i;
        mmp_pkg::CFG_CHAR_GAP:   char_gap_q <= cfg_data_i[mmp_pkg::MULT_W-1:0];
        mmp_pkg::CFG_WORD_GAP:   word_gap_q <= cfg_data_i[mmp_pkg::MULT_W-1:0];
        default: ;
      endcase
    end
  end

  // result queue
  assign res_empty_o = (res_cnt_q == 2'd0);
  assign res_o       = res_mem_q[res_rd_q];
  assign res_pop     = res_pop_i && !res_empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wr_q  <= 1'b0;
      res_rd_q  <= 1'b0;
      res_cnt_q <= 2'd0;
    end else begin
      res_wr_q  <= res_wr_q ^ res_push;
      res_rd_q  <= res_rd_q ^ res_pop;
      res_cnt_q <= res_cnt_q + {1'b0, res_push} - {1'b0, res_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_mem_q[res_wr_q] <= res_new;
    end
  end

endmodule

// ----- rtl/morse_message_player.sv -----
// top level of the morse message player
// Plays one of five canned Morse messages. Each input beat is a 1 ms tick, a play request, a
// stop request or an unused code, and each gives exactly one result beat with the key state,
// playing flag, slot and play acceptance. Requests are decoded into a two-entry command queue;
// a sequencer takes one command at a time when the two-entry result queue has room. A tick that
// does not end a phase passes through the exec and emit states of the sequencer, starting the
// next element adds the start state, and fetching the next character adds a load state per
// message character read from the rom, spaces included. Configuration writes are taken in any
// cycle and must only be issued while no command is in flight. No clearing pass runs after reset.
module morse_message_player (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [mmp_pkg::CFGI_W-1:0]  cfg_index_i,
  input  logic [mmp_pkg::DIT_W-1:0]   cfg_data_i,
  input  logic                        push,
  output logic                        full,
  input  logic [mmp_pkg::REQ_W-1:0]   req_type_i,
  input  logic [mmp_pkg::SLOT_W-1:0]  slot_i,
  input  logic                        tx_active_i,
  input  logic                        tone_grant_i,
  output logic                        empty,
  input  logic                        pop,
  output logic                        tone_on_o,
  output logic                        playing_o,
  output logic [mmp_pkg::SLOT_W-1:0]  playing_slot_o,
  output logic                        play_accepted_o
);

  logic          cmd_valid;
  logic          cmd_pop;
  mmp_pkg::cmd_t cmd;
  mmp_pkg::res_t res;

  mmp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .req_type_i   (req_type_i),
    .slot_i       (slot_i),
    .tx_active_i  (tx_active_i),
    .tone_grant_i (tone_grant_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  mmp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_empty_o (empty),
    .res_pop_i   (pop),
    .res_o       (res)
  );

  assign tone_on_o       = res.tone_on;
  assign playing_o       = res.playing;
  assign playing_slot_o  = res.slot;
  assign play_accepted_o = res.accepted;

endmodule

// ----- rtl/mmp_checker.sv -----
// port-level checks of the message player and their binding
`include "assert_macros.svh"

module mmp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        empty,
  input logic                        pop,
  input logic                        tone_on_o,
  input logic                        playing_o,
  input logic [mmp_pkg::SLOT_W-1:0]  playing_slot_o,
  input logic                        play_accepted_o
);

  logic [mmp_pkg::SLOT_W+2:0] res_beat;

  assign res_beat = {tone_on_o, playing_o, playing_slot_o, play_accepted_o};

  // key down only while a message plays
  `MMP_ASSERT(a_tone_needs_play, !empty |-> (!tone_on_o || playing_o), "tone on while idle")

  // an accepted play leaves playback running
  `MMP_ASSERT(a_accept_needs_play, !empty |-> (!play_accepted_o || playing_o), "accept w/o play")

  // refused slots never reach the slot register
  `MMP_ASSERT(a_slot_range, !empty |-> (int'(playing_slot_o) < mmp_pkg::SLOT_COUNT), "bad slot")

  // a waiting result beat stays put
  `MMP_ASSERT(a_result_holds, (!empty && !pop) |=> (!empty && $stable(res_beat)), "beat moved")

  // no result beat survives reset
  `MMP_ASSERT_RST(a_reset_empty, !rst_ni |=> empty, "result queue not empty after reset")

endmodule

bind morse_message_player mmp_checker u_mmp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .empty           (empty),
  .pop             (pop),
  .tone_on_o       (tone_on_o),
  .playing_o       (playing_o),
  .playing_slot_o  (playing_slot_o),
  .play_accepted_o (play_accepted_o)
);

// ----- verif/mmp_play_checker.sv -----
// result checker for the morse message player: predicts every result beat and compares it
module mmp_play_checker
  import mmp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [CFGI_W-1:0] cfg_index_i,
  input  logic [DIT_W-1:0]  cfg_data_i,
  input  logic              push_i,
  input  logic              full_i,
  input  logic [REQ_W-1:0]  req_type_i,
  input  logic [SLOT_W-1:0] slot_i,
  input  logic              tx_active_i,
  input  logic              tone_grant_i,
  input  logic              empty_i,
  input  logic              pop_i,
  input  logic              tone_on_i,
  input  logic              playing_i,
  input  logic [SLOT_W-1:0] playing_slot_i,
  input  logic              play_accepted_i,
  output int                fail_count_o,
  output int                pending_o
);

  typedef struct packed {
    logic              tone_on;
    logic              playing;
    logic [SLOT_W-1:0] slot;
    logic              accepted;
  } play_beat_t;

  string msg_text [SLOT_COUNT] = '{"CQ CQ CQ", "599 599", "TU TU", "QRZ?", "AR AR"};
  string letter_code [26] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
    "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
    "..-", "...-", ".--", "-..-", "-.--", "--.."
  };
  string digit_code [10] = '{
    "-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...",
    "---..", "----."
  };

  // keyer settings
  logic [DIT_W-1:0]  dit_ms;
  logic [MULT_W-1:0] char_mult;
  logic [MULT_W-1:0] word_mult;

  // playback state
  logic                    active;
  logic [SLOT_W-1:0]       cur_slot;
  int                      char_idx;
  logic [MAX_ELEMENTS-1:0] dah_mask;
  int                      elem_count;
  int                      elem_idx;
  phase_e                  phase;
  int unsigned             elapsed_ms;
  int unsigned             duration_ms;

  play_beat_t expected_beats [$];
  int         fail_count = 0;

  initial fail_count_o = 0;
  initial pending_o = 0;

  function automatic logic [CHAR_W-1:0] text_char(logic [SLOT_W-1:0] s, int i);
    if (int'(s) >= SLOT_COUNT || i >= MAX_MSG_CHARS || i >= msg_text[s].len()) return CH_NUL;
    return msg_text[s][i];
  endfunction

  // fills dah_mask and elem_count and clears elem_idx; leaves them alone for an unknown character
  function automatic bit load_pattern(logic [CHAR_W-1:0] c_in);
    logic [CHAR_W-1:0] c;
    string             code;
    int                n;
    c = c_in;
    code = "";
    if (c >= "a" && c <= "z") c = c - 8'd32;
    if (c >= "A" && c <= "Z") code = letter_code[c - "A"];
    else if (c >= "0" && c <= "9") code = digit_code[c - "0"];
    else if (c == "?") code = "..--..";
    n = code.len();
    if (n == 0 || n > MAX_ELEMENTS) return 1'b0;
    dah_mask = '0;
    for (int k = 0; k < n; k++) begin
      if (code[k] == "-") dah_mask[k] = 1'b1;
    end
    elem_count = n;
    elem_idx = 0;
    return 1'b1;
  endfunction

  // spaces and unknown characters are skipped on the way to the next playable character
  function automatic bit fetch_char();
    logic [CHAR_W-1:0] c;
    bit                found;
    bit                done;
    found = 1'b0;
    done = 1'b0;
    while (!done) begin
      while (text_char(cur_slot, char_idx) == CH_SPACE) char_idx++;
      c = text_char(cur_slot, char_idx);
      if (c == CH_NUL) begin
        done = 1'b1;
      end else begin
        char_idx++;
        if (load_pattern(c)) begin
          found = 1'b1;
          done = 1'b1;
        end
      end
    end
    return found;
  endfunction

  function automatic void halt_play();
    active = 1'b0;
    phase = PH_IDLE;
  endfunction

  function automatic void start_tone(bit grant);
    bit dah;
    if (!grant) begin
      halt_play();
      return;
    end
    dah = (elem_idx < MAX_ELEMENTS) && dah_mask[elem_idx];
    phase = PH_TONE;
    elapsed_ms = 0;
    duration_ms = dah ? int'(dit_ms) * 3 : int'(dit_ms);
  endfunction

  function automatic void start_gap(int unsigned len);
    phase = PH_GAP;
    elapsed_ms = 0;
    duration_ms = len;
  endfunction

  function automatic void on_tick(bit grant);
    logic [CHAR_W-1:0] nx;
    if (!active) return;
    if (elapsed_ms < 65535) elapsed_ms++;
    if (elapsed_ms < duration_ms) return;
    if (phase == PH_TONE) begin
      elem_idx++;
      if (elem_idx < elem_count) begin
        start_gap(int'(dit_ms));
      end else begin
        // a word gap when a space or the end of the text follows
        nx = text_char(cur_slot, char_idx);
        start_gap(int'(dit_ms) *
                  int'((nx == CH_SPACE || nx == CH_NUL) ? word_mult : char_mult));
      end
      return;
    end
    if (elem_idx < elem_count) begin
      start_tone(grant);
      return;
    end
    if (!fetch_char()) begin
      halt_play();
      return;
    end
    start_tone(grant);
  endfunction

  function automatic bit on_play(logic [SLOT_W-1:0] s, bit tx, bit grant);
    if (int'(s) >= SLOT_COUNT || tx) return 1'b0;
    halt_play();
    cur_slot = s;
    char_idx = 0;
    active = 1'b1;
    if (!fetch_char()) begin
      active = 1'b0;
      return 1'b0;
    end
    start_tone(grant);
    return active;
  endfunction

  function automatic play_beat_t predict_beat(logic [REQ_W-1:0] req, logic [SLOT_W-1:0] s,
                                              bit tx, bit grant);
    play_beat_t b;
    bit         acc;
    acc = 1'b0;
    case (req)
      REQ_TICK: on_tick(grant);
      REQ_PLAY: acc = on_play(s, tx, grant);
      REQ_STOP: halt_play();
      default: ;
    endcase
    b.tone_on  = active && (phase == PH_TONE);
    b.playing  = active;
    b.slot     = cur_slot;
    b.accepted = acc;
    return b;
  endfunction

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    play_beat_t want;
    play_beat_t got;
    if (!rst_ni) begin
      dit_ms      = DIT_RESET;
      char_mult   = CHAR_GAP_RESET;
      word_mult   = WORD_GAP_RESET;
      active      = 1'b0;
      cur_slot    = '0;
      char_idx    = 0;
      dah_mask    = '0;
      elem_count  = 0;
      elem_idx    = 0;
      phase       = PH_IDLE;
      elapsed_ms  = 0;
      duration_ms = 0;
      expected_beats.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_DIT_LENGTH: dit_ms = cfg_data_i;
          CFG_CHAR_GAP:   char_mult = cfg_data_i[MULT_W-1:0];
          CFG_WORD_GAP:   word_mult = cfg_data_i[MULT_W-1:0];
          default: ;
        endcase
      end
      // result side first so a beat never meets the prediction made in the same cycle
      if (pop_i && !empty_i) begin
        got = '{tone_on_i, playing_i, playing_slot_i, play_accepted_i};
        if (expected_beats.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with nothing predicted, expected none, got %h",
                   $time, got);
        end else begin
          want = expected_beats.pop_front();
          compare_field("tone_on", want.tone_on, got.tone_on);
          compare_field("playing", want.playing, got.playing);
          compare_field("playing_slot", want.slot, got.slot);
          compare_field("play_accepted", want.accepted, got.accepted);
        end
      end
      if (push_i && !full_i) begin
        expected_beats.push_back(predict_beat(req_type_i, slot_i, tx_active_i, tone_grant_i));
      end
      pending_o <= expected_beats.size();
      fail_count_o <= fail_count;
    end
  end

endmodule

// ----- verif/tb_morse_message_player.sv -----
// testbench top for the morse message player: reset, keyer settings, request stimulus, verdict
module tb_morse_message_player;
  import mmp_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASES       = 7;

  typedef enum logic [1:0] {
    RX_STREAM,
    RX_RANDOM,
    RX_SPARSE
  } rx_mode_e;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CFGI_W-1:0] cfg_index_i = CFG_DIT_LENGTH;
  logic [DIT_W-1:0]  cfg_data_i = '0;
  logic              push = 1'b0;
  logic              full;
  logic [REQ_W-1:0]  req_type_i = REQ_TICK;
  logic [SLOT_W-1:0] slot_i = '0;
  logic              tx_active_i = 1'b0;
  logic              tone_grant_i = 1'b0;
  logic              empty;
  logic              pop = 1'b0;
  logic              tone_on_o;
  logic              playing_o;
  logic [SLOT_W-1:0] playing_slot_o;
  logic              play_accepted_o;

  int       fail_count;
  int       pending;
  int       burst_left = 8;
  int       quiet_cycles = 0;
  logic [7:0] rx_cycle = '0;
  rx_mode_e rx_mode = RX_STREAM;

  // settings per random phase: dit lengths from 0 to 2000, gap multipliers from 1 up to their maximum of 15
  int unsigned dit_set   [PHASES] = '{1, 0, 2, 10, 2000, 5, 33};
  int unsigned cgap_set  [PHASES] = '{1, 15, 2, 3, 15, 1, 4};
  int unsigned wgap_set  [PHASES] = '{1, 15, 7, 7, 1, 15, 8};
  int unsigned items_set [PHASES] = '{80, 80, 70, 60, 30, 60, 70};

  always #10 clk_i = ~clk_i;

  morse_message_player dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .push           (push),
    .full           (full),
    .req_type_i     (req_type_i),
    .slot_i         (slot_i),
    .tx_active_i    (tx_active_i),
    .tone_grant_i   (tone_grant_i),
    .empty          (empty),
    .pop            (pop),
    .tone_on_o      (tone_on_o),
    .playing_o      (playing_o),
    .playing_slot_o (playing_slot_o),
    .play_accepted_o(play_accepted_o)
  );

  mmp_play_checker beat_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .push_i         (push),
    .full_i         (full),
    .req_type_i     (req_type_i),
    .slot_i         (slot_i),
    .tx_active_i    (tx_active_i),
    .tone_grant_i   (tone_grant_i),
    .empty_i        (empty),
    .pop_i          (pop),
    .tone_on_i      (tone_on_o),
    .playing_i      (playing_o),
    .playing_slot_i (playing_slot_o),
    .play_accepted_i(play_accepted_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // result side: streams, stalls at random, or takes one beat in eight
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 8'd1;
    if (rx_cycle[5:0] == 6'd0) rx_mode <= rx_mode_e'($urandom_range(0, 2));
    case (rx_mode)
      RX_STREAM: pop <= 1'b1;
      RX_RANDOM: pop <= ($urandom_range(0, 3) != 0);
      default:   pop <= (rx_cycle[2:0] == 3'd0);
    endcase
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("morse_message_player: mismatch");
        $finish;
      end
    end
  end

  // one request beat; a burst ends in a gap of random length
  task automatic send_req(logic [REQ_W-1:0] req, logic [SLOT_W-1:0] s, bit tx, bit grant);
    int gap;
    req_type_i   <= req;
    slot_i       <= s;
    tx_active_i  <= tx;
    tone_grant_i <= grant;
    push         <= 1'b1;
    do @(posedge clk_i); while (full);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_all_results();
    push <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // writes all three registers; upper data bits of the gap registers are don't-care
  task automatic set_keyer(logic [DIT_W-1:0] dit, logic [MULT_W-1:0] cgap,
                           logic [MULT_W-1:0] wgap);
    logic [DIT_W-1:0] junk;
    junk = DIT_W'($urandom);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_DIT_LENGTH;
    cfg_data_i  <= dit;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CFG_CHAR_GAP;
    cfg_data_i  <= {junk[DIT_W-1:MULT_W], cgap};
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CFG_WORD_GAP;
    cfg_data_i  <= {~junk[DIT_W-1:MULT_W], wgap};
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly ticks so playback gets deep into the messages
  task automatic random_req();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 94) begin
      send_req(REQ_TICK, SLOT_W'($urandom), 1'($urandom), $urandom_range(0, 19) != 0);
    end else if (pick < 97) begin
      send_req(REQ_PLAY,
               ($urandom_range(0, 7) == 0) ? SLOT_W'($urandom_range(5, 7))
                                           : SLOT_W'($urandom_range(0, 4)),
               $urandom_range(0, 5) == 0, $urandom_range(0, 9) != 0);
    end else if (pick < 99) begin
      send_req(REQ_STOP, SLOT_W'($urandom), 1'($urandom), 1'($urandom));
    end else begin
      send_req(REQ_UNUSED, SLOT_W'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: idle tick, refused plays, unused request, refused tone, then plays, ticks and a stop
    send_req(REQ_TICK, 3'd7, 1'b1, 1'b1);
    send_req(REQ_PLAY, 3'd5, 1'b0, 1'b1);
    send_req(REQ_PLAY, 3'd7, 1'b0, 1'b1);
    send_req(REQ_PLAY, 3'd0, 1'b1, 1'b1);
    send_req(REQ_UNUSED, 3'd2, 1'b0, 1'b1);
    send_req(REQ_PLAY, 3'd0, 1'b0, 1'b0);
    send_req(REQ_PLAY, 3'd4, 1'b0, 1'b1);
    send_req(REQ_TICK, 3'd0, 1'b0, 1'b1);
    send_req(REQ_TICK, 3'd0, 1'b0, 1'b1);
    send_req(REQ_PLAY, 3'd3, 1'b1, 1'b1);
    send_req(REQ_PLAY, 3'd1, 1'b0, 1'b1);
    send_req(REQ_STOP, 3'd6, 1'b1, 1'b0);

    // zero dit length: every tick moves one step, question mark in slot 3
    wait_all_results();
    set_keyer(11'd0, 4'd1, 4'd1);
    send_req(REQ_PLAY, 3'd3, 1'b0, 1'b1);
    repeat (10) send_req(REQ_TICK, 3'd0, 1'b0, 1'b1);
    send_req(REQ_TICK, 3'd0, 1'b0, 1'b0);
    send_req(REQ_TICK, 3'd0, 1'b0, 1'b1);
    send_req(REQ_PLAY, 3'd2, 1'b0, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      wait_all_results();
      set_keyer(DIT_W'(dit_set[p]), MULT_W'(cgap_set[p]), MULT_W'(wgap_set[p]));
      repeat (items_set[p]) random_req();
    end

    wait_all_results();
    if (fail_count == 0) begin
      $display("morse_message_player: match");
    end else begin
      $display("morse_message_player: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/mmp_pkg.sv
rtl/mmp_front.sv
rtl/mmp_back.sv
rtl/morse_message_player.sv
rtl/mmp_checker.sv
verif/mmp_play_checker.sv
verif/tb_morse_message_player.sv
